>>> hw/rtl/htq_pkg.sv
// Package for the heap timer queue: shared constants, command and result codes.
// No dependencies.
package htq_pkg;
	localparam int CAPACITY_DEF = 32;
	localparam int TICK_BITS_DEF = 32;
	localparam int ID_BITS = 5;
	localparam int NUM_TIMERS = 32;
	localparam int IVAL_BITS = 31;
	localparam int OUT_TICK_BITS = 32;

	localparam logic [1:0] CMD_SCHED = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] KIND_EXPIRED = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;
endpackage

>>> hw/rtl/htq_cmp.sv
// Shared deadline adder/subtractor: a + b, or a - b with carry out (no borrow).
// Depends on htq_pkg for the default width; pure logic.
module htq_cmp #(
	parameter int TICK_BITS = htq_pkg::TICK_BITS_DEF
) (
	input  logic [TICK_BITS-1:0] a,
	input  logic [TICK_BITS-1:0] b,
	input  logic                 sub,
	output logic [TICK_BITS-1:0] res,
	output logic                 carry
);
	logic [TICK_BITS:0] full;
	assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{TICK_BITS{1'b0}}, sub};
	assign res = full[TICK_BITS-1:0];
	assign carry = full[TICK_BITS];
endmodule

>>> hw/rtl/heap_timer_queue.sv
// Heap timer queue top level: command sequencer, heap memory and slot table.
// Depends on htq_pkg and htq_cmp.
//
// Usage: one request channel (cmd, timer_id, now, interval) with in_valid and
// in_ready, one result channel (kind, expired_id, next_valid, next_deadline,
// last) with out_valid and out_ready. Every request gives exactly one result
// with last set; a run first gives one expired result per timer due at now.
//
// The block handles one request at a time; in_ready is high only while the
// sequencer is idle. All arithmetic goes through one shared adder/subtractor;
// the heap memory gives one registered read and takes one write per cycle.
// A reject goes from the check straight to its result. A schedule appends at
// the end and climbs the heap; a cancel moves the last entry into the freed
// slot where needed and climbs or sifts it down. A run checks the root against
// now, removes each expired timer with a sift-down, then gives the final result.
//
// Reset clears the entry count, the slot table and the output register; the
// heap memory is not cleared. When the receiver stalls, the result waits in
// the output register and the sequencer holds at its next result.
module heap_timer_queue #(
	parameter int CAPACITY = htq_pkg::CAPACITY_DEF,
	parameter int TICK_BITS = htq_pkg::TICK_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [htq_pkg::ID_BITS-1:0]       timer_id,
	input  logic [htq_pkg::OUT_TICK_BITS-1:0] now,
	input  logic [htq_pkg::IVAL_BITS-1:0]     interval,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic [htq_pkg::ID_BITS-1:0]       expired_id,
	output logic                              next_valid,
	output logic [htq_pkg::OUT_TICK_BITS-1:0] next_deadline,
	output logic                              last
);
	localparam int SB = $clog2(CAPACITY + 1);   // slot, count and address width
	localparam int IB = htq_pkg::ID_BITS;
	localparam int NT = htq_pkg::NUM_TIMERS;
	localparam logic [TICK_BITS-1:0] SIGN = {1'b1, {(TICK_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_RM, ST_RM_LD, ST_UP_RD, ST_UP_CMP, ST_PLACE,
		ST_DN_RDL, ST_DN_KL, ST_DN_KR, ST_DN_SEL, ST_RUN_RD, ST_RUN_CHK, ST_OUT
	} state_t;

	typedef struct packed {
		logic [IB-1:0]        id;
		logic [TICK_BITS-1:0] dl;
	} entry_t;

	state_t state_q;
	state_t done_st;
	logic [1:0] cmd_q;
	logic [IB-1:0] id_q;
	logic [TICK_BITS-1:0] now_q;
	logic [TICK_BITS-1:0] ival_q;
	logic [SB-1:0] count_q;
	logic [SB-1:0] cur_q;        // hole slot of the moving entry
	entry_t cur_e_q;             // moving entry, written only at its final slot
	entry_t l_e_q, r_e_q;        // children of the hole during sift-down
	logic [TICK_BITS-1:0] key_l_q, key_r_q;  // offset-binary child - moving
	logic first_q;               // cancel's first parent check is not-later

	// pending final result
	logic [1:0] pk_q;
	logic pnv_q;
	logic [TICK_BITS-1:0] pnd_q;

	// heap memory, slots 1..CAPACITY
	entry_t heap_mem [CAPACITY+1];
	logic [SB-1:0] rd_addr;
	entry_t rd_data_q;
	logic wr_en;
	logic [SB-1:0] wr_addr;
	entry_t wr_data;

	// slot table, 0 = unscheduled
	logic [SB-1:0] slot_q [NT];

	// output register
	logic ov_q;
	logic [1:0] okind_q;
	logic [IB-1:0] oid_q;
	logic onv_q;
	logic [TICK_BITS-1:0] ond_q;
	logic olast_q;

	// shared adder/subtractor
	logic [TICK_BITS-1:0] alu_a, alu_b, alu_res;
	logic alu_sub, alu_co;
	logic alu_le, alu_neg, alu_ult;
	htq_cmp #(.TICK_BITS(TICK_BITS)) u_cmp (
		.a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .carry(alu_co)
	);
	assign alu_neg = alu_res[TICK_BITS-1];
	assign alu_le = alu_res[TICK_BITS-1] | (alu_res == '0);
	assign alu_ult = !alu_co;

	logic [SB:0] lslot, rslot;
	logic l_is_last, l_beyond;
	assign lslot = {cur_q, 1'b0};
	assign rslot = {cur_q, 1'b1};
	assign l_is_last = (lslot == {1'b0, count_q});
	assign l_beyond = (lslot > {1'b0, count_q});

	logic up_swap, dn_go, dn_left;
	entry_t dn_e;
	assign up_swap = first_q ? alu_le : !alu_le;
	// stop when neither child is strictly earlier; equal keys pick the right
	assign dn_go = !(key_l_q[TICK_BITS-1] && key_r_q[TICK_BITS-1]);
	assign dn_left = alu_ult;
	assign dn_e = dn_left ? l_e_q : r_e_q;

	logic emit_ok, out_load;
	assign emit_ok = !ov_q || out_ready;
	assign out_load = emit_ok &&
		(state_q == ST_OUT || (state_q == ST_RUN_CHK && alu_le));

	assign done_st = (cmd_q == htq_pkg::CMD_RUN) ? ST_RUN_RD : ST_OUT;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign kind = okind_q;
	assign expired_id = oid_q;
	assign next_valid = onv_q;
	assign next_deadline = htq_pkg::OUT_TICK_BITS'(ond_q);
	assign last = olast_q;

	always_ff @(posedge clk) begin
		rd_data_q <= heap_mem[rd_addr];
		if (wr_en) heap_mem[wr_addr] <= wr_data;
	end

	// memory read address by state
	always_comb begin
		rd_addr = cur_q;
		case (state_q)
			ST_RM:      rd_addr = count_q;
			ST_UP_RD:   rd_addr = cur_q >> 1;
			ST_DN_RDL:  rd_addr = l_beyond ? cur_q : SB'(lslot);
			ST_DN_KL:   rd_addr = l_is_last ? cur_q : SB'(rslot);
			ST_RUN_RD:  rd_addr = SB'(1);
			ST_RUN_CHK: rd_addr = SB'(1);
			default: ;
		endcase
	end

	// shared unit operands by state
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b1;
		case (state_q)
			ST_CHK: begin
				alu_a = now_q; alu_b = ival_q; alu_sub = 1'b0;
			end
			ST_UP_CMP: begin
				// first check: moving not later than parent; else parent later
				alu_a = first_q ? cur_e_q.dl : rd_data_q.dl;
				alu_b = first_q ? rd_data_q.dl : cur_e_q.dl;
			end
			ST_DN_KL, ST_DN_KR: begin
				alu_a = rd_data_q.dl; alu_b = cur_e_q.dl;
			end
			ST_DN_SEL: begin
				alu_a = key_l_q; alu_b = key_r_q;
			end
			ST_RUN_CHK: begin
				alu_a = rd_data_q.dl; alu_b = now_q;
			end
			default: ;
		endcase
	end

	// one heap write per cycle: move a neighbor into the hole, or place
	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_data = cur_e_q;
		case (state_q)
			ST_UP_CMP: begin
				wr_en = up_swap; wr_data = rd_data_q;
			end
			ST_PLACE: wr_en = 1'b1;
			ST_DN_KL: begin
				wr_en = l_is_last && alu_neg; wr_data = rd_data_q;
			end
			ST_DN_SEL: begin
				wr_en = dn_go; wr_data = dn_e;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= htq_pkg::CMD_SCHED;
			id_q <= '0;
			now_q <= '0;
			ival_q <= '0;
			count_q <= '0;
			cur_q <= '0;
			cur_e_q <= '0;
			l_e_q <= '0;
			r_e_q <= '0;
			key_l_q <= '0;
			key_r_q <= '0;
			first_q <= 1'b0;
			pk_q <= htq_pkg::KIND_DONE;
			pnv_q <= 1'b0;
			pnd_q <= '0;
			for (int k = 0; k < NT; k++) slot_q[k] <= '0;
			ov_q <= 1'b0;
			okind_q <= htq_pkg::KIND_DONE;
			oid_q <= '0;
			onv_q <= 1'b0;
			ond_q <= '0;
			olast_q <= 1'b0;
		end else begin
			ov_q <= out_load || (ov_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q <= cmd; id_q <= timer_id;
						now_q <= TICK_BITS'(now);
						ival_q <= TICK_BITS'(interval);
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					pnv_q <= 1'b0; pnd_q <= '0;
					case (cmd_q)
						htq_pkg::CMD_SCHED: begin
							if (slot_q[id_q] != '0 || count_q >= SB'(CAPACITY)) begin
								pk_q <= htq_pkg::KIND_REJECT; state_q <= ST_OUT;
							end else begin
								// append at the end, then climb
								pk_q <= htq_pkg::KIND_DONE;
								count_q <= count_q + 1'b1;
								cur_q <= count_q + 1'b1;
								cur_e_q <= '{id: id_q, dl: alu_res};
								first_q <= 1'b0;
								state_q <= (count_q == '0) ? ST_PLACE : ST_UP_RD;
							end
						end
						htq_pkg::CMD_CANCEL: begin
							if (slot_q[id_q] == '0) begin
								pk_q <= htq_pkg::KIND_REJECT; state_q <= ST_OUT;
							end else begin
								pk_q <= htq_pkg::KIND_DONE;
								cur_q <= slot_q[id_q];
								state_q <= ST_RM;
							end
						end
						htq_pkg::CMD_RUN: state_q <= ST_RUN_RD;
						default: begin
							pk_q <= htq_pkg::KIND_REJECT; state_q <= ST_OUT;
						end
					endcase
				end
				ST_RM: begin
					// drop timer id_q at cur_q; fetch the last entry if it must move
					slot_q[id_q] <= '0;
					count_q <= count_q - 1'b1;
					if (cur_q == count_q) state_q <= done_st;
					else state_q <= ST_RM_LD;
				end
				ST_RM_LD: begin
					cur_e_q <= rd_data_q;
					if (cur_q > SB'(1)) begin
						first_q <= 1'b1; state_q <= ST_UP_RD;
					end else state_q <= ST_DN_RDL;
				end
				ST_UP_RD: state_q <= ST_UP_CMP;
				ST_UP_CMP: begin
					if (up_swap) begin
						// parent moves down into the hole
						slot_q[rd_data_q.id] <= cur_q;
						cur_q <= cur_q >> 1;
						first_q <= 1'b0;
						state_q <= ((cur_q >> 1) > SB'(1)) ? ST_UP_RD : ST_PLACE;
					end else if (first_q) begin
						first_q <= 1'b0; state_q <= ST_DN_RDL;
					end else state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					slot_q[cur_e_q.id] <= cur_q;
					state_q <= done_st;
				end
				ST_DN_RDL: state_q <= l_beyond ? ST_PLACE : ST_DN_KL;
				ST_DN_KL: begin
					l_e_q <= rd_data_q;
					key_l_q <= alu_res ^ SIGN;
					if (l_is_last) begin
						// single child: move it up only if strictly earlier
						if (alu_neg) begin
							slot_q[rd_data_q.id] <= cur_q;
							cur_q <= SB'(lslot);
						end
						state_q <= ST_PLACE;
					end else state_q <= ST_DN_KR;
				end
				ST_DN_KR: begin
					r_e_q <= rd_data_q;
					key_r_q <= alu_res ^ SIGN;
					state_q <= ST_DN_SEL;
				end
				ST_DN_SEL: begin
					if (dn_go) begin
						slot_q[dn_e.id] <= cur_q;
						cur_q <= dn_left ? SB'(lslot) : SB'(rslot);
						state_q <= ST_DN_RDL;
					end else state_q <= ST_PLACE;
				end
				ST_RUN_RD: begin
					if (count_q == '0) begin
						pk_q <= htq_pkg::KIND_DONE; pnv_q <= 1'b0; pnd_q <= '0;
						state_q <= ST_OUT;
					end else state_q <= ST_RUN_CHK;
				end
				ST_RUN_CHK: begin
					if (alu_le) begin
						// root is due: hold until the output register frees
						if (emit_ok) begin
							okind_q <= htq_pkg::KIND_EXPIRED;
							oid_q <= rd_data_q.id; onv_q <= 1'b0; ond_q <= '0;
							olast_q <= 1'b0;
							id_q <= rd_data_q.id; cur_q <= SB'(1);
							state_q <= ST_RM;
						end
					end else begin
						pk_q <= htq_pkg::KIND_DONE; pnv_q <= 1'b1;
						pnd_q <= rd_data_q.dl;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (emit_ok) begin
						okind_q <= pk_q; oid_q <= '0; onv_q <= pnv_q;
						ond_q <= pnd_q; olast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/htq_checker.sv
// Port-level checker for the heap timer queue, bound to the top level.
// Depends on htq_pkg and the heap_timer_queue ports.
module htq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic       last,
	input logic       next_valid
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
		else $error("result dropped while stalled");
	a_exp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == htq_pkg::KIND_EXPIRED |-> !last)
		else $error("expired result marked last");
	a_nv_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_valid |-> last && kind == htq_pkg::KIND_DONE)
		else $error("next_valid outside final run result");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");
endmodule

bind heap_timer_queue htq_checker u_htq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last),
	.next_valid(next_valid)
);
